@@ rtl/sdt_pkg.sv @@
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared types and constants of the screen tile detiler.
// ----------------------------------------------------------------------------
package sdt_pkg;

	// Register index codes of the configuration channel.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PACKED_MODE   = 3'd4;

	localparam int BYTE_W    = 8;
	localparam int SIZE_W    = 8;
	localparam int NIBBLE_W  = 4;
	localparam int OUT_ADDR_W = 16;

	// Reset values of the size registers.
	localparam logic [SIZE_W-1:0] RST_MAP_WIDTH     = 8'd1;
	localparam logic [SIZE_W-1:0] RST_MAP_HEIGHT    = 8'd1;
	localparam logic [SIZE_W-1:0] RST_SCREEN_WIDTH  = 8'd15;
	localparam logic [SIZE_W-1:0] RST_SCREEN_HEIGHT = 8'd10;

	// Tile queue between front and back.
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = 2;
	localparam int QCNT_W  = 3;

	// One tile as handed from the front to the back.
	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              last;
	} sdt_tile_t;

	// Map geometry as seen by the back.
	typedef struct packed {
		logic [SIZE_W-1:0] screens_across;
		logic [SIZE_W-1:0] screens_down;
		logic [SIZE_W-1:0] tiles_across;
		logic [SIZE_W-1:0] tiles_down;
	} sdt_geom_t;

endpackage

@@ rtl/sdt_front.sv @@
// ----------------------------------------------------------------------------
// sdt_front
// Accepts input bytes and splits each into one tile, or two nibble tiles
// high nibble first in packed mode.
// ----------------------------------------------------------------------------
module sdt_front import sdt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              packed_mode,
	output logic              push,
	output sdt_tile_t         push_tile,
	input  logic              q_full
);

	logic              hold_q;
	logic              packed_q;
	logic              phase_q;
	logic [BYTE_W-1:0] byte_q;
	logic              first_half;
	logic              accept;

	// The high nibble goes first; the low nibble (or the whole byte) closes it.
	assign first_half = packed_q && !phase_q;
	assign push       = hold_q && !q_full;
	assign in_ready   = !hold_q || (push && !first_half);
	assign accept     = in_valid && in_ready;

	always_comb begin
		push_tile.last = !first_half;
		if (first_half) begin
			push_tile.value = {{(BYTE_W-NIBBLE_W){1'b0}}, byte_q[BYTE_W-1:NIBBLE_W]};
		end else if (packed_q) begin
			push_tile.value = {{(BYTE_W-NIBBLE_W){1'b0}}, byte_q[NIBBLE_W-1:0]};
		end else begin
			push_tile.value = byte_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (accept) begin
			hold_q  <= 1'b1;
			phase_q <= 1'b0;
		end else if (push && !first_half) begin
			hold_q  <= 1'b0;
		end else if (push) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q   <= in_byte;
			packed_q <= packed_mode;
		end
	end

endmodule

@@ rtl/sdt_queue.sv @@
// ----------------------------------------------------------------------------
// sdt_queue
// Short tile queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module sdt_queue import sdt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  sdt_tile_t push_tile,
	output logic      full,
	input  logic      pop,
	output sdt_tile_t pop_tile,
	output logic      empty
);

	sdt_tile_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign empty    = (count_q == '0);
	assign pop_tile = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tile;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("tile queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("tile queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH)) else $error("tile queue count out of range");

endmodule

@@ rtl/sdt_back.sv @@
// ----------------------------------------------------------------------------
// sdt_back
// Position counters and a two-stage address pipeline ending in an output register.
// ----------------------------------------------------------------------------
module sdt_back import sdt_pkg::*; #(
	parameter int ADDR_BITS = 16,
	parameter int DIM_BITS  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sdt_geom_t             geom,
	input  logic                  q_empty,
	input  sdt_tile_t             q_tile,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ADDR_BITS-1:0]  out_addr,
	output logic [BYTE_W-1:0]     out_value,
	output logic                  out_last,
	output logic                  out_done
);

	localparam int CW = (DIM_BITS + 1 > SIZE_W) ? DIM_BITS + 1 : SIZE_W;
	localparam int PW = DIM_BITS + SIZE_W + 1;

	function automatic logic wraps(input logic [DIM_BITS-1:0] cnt,
	                               input logic [SIZE_W-1:0] size);
		logic [CW-1:0] nxt;
		nxt = CW'(cnt) + CW'(1);
		return (nxt >= CW'(size)) || nxt[DIM_BITS];
	endfunction

	logic [DIM_BITS-1:0]  tile_col_q, tile_row_q, screen_col_q, screen_row_q;
	logic [ADDR_BITS-1:0] stride_q;
	logic                 wrap_tc, wrap_tr, wrap_sc, wrap_sr;
	logic [PW-1:0]        row_wide, col_wide;
	logic                 load_s1, out_free;

	logic                 valid_s1;
	logic [ADDR_BITS-1:0] row_s1, col_s1;
	logic [BYTE_W-1:0]    value_s1;
	logic                 last_s1, done_s1;

	logic                 valid_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [BYTE_W-1:0]    value_q;
	logic                 last_q, done_q;

	assign out_free = !valid_q || out_ready;
	assign load_s1  = !valid_s1 || out_free;
	assign pop      = load_s1 && !q_empty;

	assign wrap_tc = wraps(tile_col_q, geom.tiles_across);
	assign wrap_tr = wraps(tile_row_q, geom.tiles_down);
	assign wrap_sc = wraps(screen_col_q, geom.screens_across);
	assign wrap_sr = wraps(screen_row_q, geom.screens_down);

	assign row_wide = PW'(screen_row_q) * PW'(geom.tiles_down) + PW'(tile_row_q);
	assign col_wide = PW'(screen_col_q) * PW'(geom.tiles_across) + PW'(tile_col_q);

	// Row stride of the whole map; only low address bits matter.
	always_ff @(posedge clk) begin
		stride_q <= ADDR_BITS'(geom.screens_across) * ADDR_BITS'(geom.tiles_across);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_col_q   <= '0;
			tile_row_q   <= '0;
			screen_col_q <= '0;
			screen_row_q <= '0;
		end else if (pop) begin
			tile_col_q <= wrap_tc ? '0 : tile_col_q + 1'b1;
			if (wrap_tc) begin
				tile_row_q <= wrap_tr ? '0 : tile_row_q + 1'b1;
				if (wrap_tr) begin
					screen_col_q <= wrap_sc ? '0 : screen_col_q + 1'b1;
					if (wrap_sc) begin
						screen_row_q <= wrap_sr ? '0 : screen_row_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= pop;
			end
			if (out_free) begin
				valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			row_s1   <= ADDR_BITS'(row_wide);
			col_s1   <= ADDR_BITS'(col_wide);
			value_s1 <= q_tile.value;
			last_s1  <= q_tile.last;
			done_s1  <= wrap_tc && wrap_tr && wrap_sc && wrap_sr;
		end
		if (out_free && valid_s1) begin
			addr_q  <= ADDR_BITS'(row_s1 * stride_q + col_s1);
			value_q <= value_s1;
			last_q  <= last_s1;
			done_q  <= done_s1;
		end
	end

	assign out_valid = valid_q;
	assign out_addr  = addr_q;
	assign out_value = value_q;
	assign out_last  = last_q;
	assign out_done  = done_q;

	a_done_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && wrap_tc && wrap_tr && wrap_sc && wrap_sr) |=>
		(tile_col_q == '0 && tile_row_q == '0 && screen_col_q == '0 &&
		 screen_row_q == '0)) else $error("counters not cleared after end of map");
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(row_s1) && $stable(col_s1)))
		else $error("address stage lost a tile under stall");

endmodule

@@ rtl/screen_tile_detiler.sv @@
// ----------------------------------------------------------------------------
// screen_tile_detiler
// Turns a screen-ordered tile dump into whole-map raster addresses.
// ----------------------------------------------------------------------------
// Path: a byte passes the front byte register, the tile queue, the address stage and the output register.
// Throughput: one tile per cycle at the output while m_axis_tready is high; a plain byte every cycle
// while the queue has room; a packed byte makes two tiles, one queue write each, and holds the input meanwhile.
// Reset: asynchronous, active low; counters and queue are emptied and the
// size registers return to 1, 1, 15, 10 with packed mode off.
// ----------------------------------------------------------------------------
module screen_tile_detiler import sdt_pkg::*; #(
	parameter int ADDR_BITS = 16,
	parameter int DIM_BITS  = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input stream. tdata: [7:0] data_byte.
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,
	// Output stream. tdata: [15:0] tile_address, [23:16] tile_value.
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [23:0]          m_axis_tdata,
	// tuser: [0] last_of_item. tlast carries map_done.
	output logic                 m_axis_tuser,
	output logic                 m_axis_tlast,
	// Configuration write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data
);

	localparam int XW = (ADDR_BITS > OUT_ADDR_W) ? ADDR_BITS : OUT_ADDR_W;

	sdt_geom_t            geom_q;
	logic                 packed_mode_q;
	logic                 push, q_full, pop, q_empty;
	sdt_tile_t            push_tile, pop_tile;
	logic [ADDR_BITS-1:0] addr;
	logic [XW-1:0]        addr_x;
	logic [BYTE_W-1:0]    value;

	// Configuration writes are always taken; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.screens_across <= RST_MAP_WIDTH;
			geom_q.screens_down   <= RST_MAP_HEIGHT;
			geom_q.tiles_across   <= RST_SCREEN_WIDTH;
			geom_q.tiles_down     <= RST_SCREEN_HEIGHT;
			packed_mode_q         <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAP_WIDTH:     geom_q.screens_across <= cfg_data;
				REG_MAP_HEIGHT:    geom_q.screens_down   <= cfg_data;
				REG_SCREEN_WIDTH:  geom_q.tiles_across   <= cfg_data;
				REG_SCREEN_HEIGHT: geom_q.tiles_down     <= cfg_data;
				REG_PACKED_MODE:   packed_mode_q         <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// The front splits each byte into tiles; packed mode is sampled per byte.
	sdt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_byte     (s_axis_tdata),
		.packed_mode (packed_mode_q),
		.push        (push),
		.push_tile   (push_tile),
		.q_full      (q_full)
	);

	sdt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_tile (push_tile),
		.full      (q_full),
		.pop       (pop),
		.pop_tile  (pop_tile),
		.empty     (q_empty)
	);

	// The back walks the four position counters and forms the raster address.
	sdt_back #(
		.ADDR_BITS (ADDR_BITS),
		.DIM_BITS  (DIM_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom_q),
		.q_empty   (q_empty),
		.q_tile    (pop_tile),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_addr  (addr),
		.out_value (value),
		.out_last  (m_axis_tuser),
		.out_done  (m_axis_tlast)
	);

	// The address is kept to ADDR_BITS and then to the 16-bit field.
	assign addr_x       = XW'(addr);
	assign m_axis_tdata = {value, addr_x[OUT_ADDR_W-1:0]};

endmodule
